@@ src/rdc_pkg.sv @@
// Shared constants and the digit-to-ASCII mapping of the radix digit converter.
// No dependencies; used by radix_digit_converter_top.
package rdc_pkg;

    localparam int VALUE_BITS_DEF  = 31;
    localparam int STACK_DEPTH_DEF = 32;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [DIGIT_W-1:0] BASE_LOW   = 6'd2;
    localparam logic [DIGIT_W-1:0] BASE_HIGH  = 6'd62;
    localparam logic [DIGIT_W-1:0] BASE_RESET = 6'd10;

    localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 6'd10;
    localparam logic [DIGIT_W-1:0] UPPER_LIMIT = 6'd36;

    localparam logic [CHAR_W-1:0] OFS_DIGIT = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0] OFS_UPPER = 7'd55;  // 'A' - 10
    localparam logic [CHAR_W-1:0] OFS_LOWER = 7'd61;  // 'a' - 36

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    function automatic t_char digit_to_ascii(input t_digit d);
        t_char ext;
        ext = {1'b0, d};
        if (d < DEC_LIMIT) begin
            return ext + OFS_DIGIT;
        end else if (d < UPPER_LIMIT) begin
            return ext + OFS_UPPER;
        end else begin
            return ext + OFS_LOWER;
        end
    endfunction

endpackage

@@ src/radix_digit_converter_top.sv @@
// Radix digit converter: writes a non-negative integer as an ASCII digit string.
// Depends on rdc_pkg for constants, types and the digit-to-ASCII mapping.

// A request on start (taken when busy is low) converts i_number_value into the
// base held in the configuration register, which resets to 10 and is clamped to
// the range 2 to 62 when a request is taken. The characters leave most
// significant first, one per strobe on o_result_strobe, and the final character
// carries o_last_digit. The receiver cannot stall: every character is shown for
// exactly one cycle and must be taken then. A zero value gives the single
// character '0'. Each digit of a request comes from a bit-serial restoring
// division in the one shared subtract-and-compare unit, and the digits are then
// popped from the digit stack at one per cycle, with the last character strobed
// in the last cycle that busy is high. If more than STACK_DEPTH digits arise,
// the most significant ones are dropped. The configuration channel is always
// ready; writes should be made while idle.
module radix_digit_converter_top #(
    parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF,
    parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [VALUE_BITS-1:0]       i_number_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rdc_pkg::DIGIT_W-1:0] i_cfg_data,
    output logic                        o_result_strobe,
    output logic [rdc_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                        o_last_digit
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam int BW = $clog2(VALUE_BITS);
    localparam int DW = rdc_pkg::DIGIT_W;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [DW-1:0]         r_target_base, n_target_base;
    logic [DW-1:0]         r_base, n_base;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [DW-1:0]         r_rem, n_rem;
    logic [BW-1:0]         r_bit, n_bit;
    logic [TW-1:0]         r_top, n_top;
    logic                  r_rd_valid, n_rd_valid;
    logic                  r_rd_last, n_rd_last;
    rdc_pkg::t_digit       r_rd_data;

    // The digit stack, written during division and read during the pop-out.
    rdc_pkg::t_digit       r_stack [STACK_DEPTH];

    logic                  accept;
    logic [DW:0]           trial;
    logic [DW:0]           diff;
    logic                  ge;
    logic [DW-1:0]         step_rem;
    logic [VALUE_BITS-1:0] step_quo;
    logic                  push_en;
    logic                  pop_en;
    logic [AW-1:0]         rd_addr;
    logic [TW-1:0]         top_dec;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // One restoring division step: shift in the next quotient bit, then subtract
    // the base from the partial remainder when it fits.
    assign trial    = {r_rem, r_quo[VALUE_BITS-1]};
    assign diff     = trial - {1'b0, r_base};
    assign ge       = (trial >= {1'b0, r_base});
    assign step_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign step_quo = {r_quo[VALUE_BITS-2:0], ge};

    assign top_dec = r_top - 1'b1;
    assign rd_addr = top_dec[AW-1:0];

    always_comb begin
        n_state       = r_state;
        n_target_base = r_target_base;
        n_base        = r_base;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_bit         = r_bit;
        n_top         = r_top;
        n_rd_valid    = 1'b0;
        n_rd_last     = r_rd_last;
        push_en       = 1'b0;
        pop_en        = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_target_base = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_target_base < rdc_pkg::BASE_LOW) begin
                        n_base = rdc_pkg::BASE_LOW;
                    end else if (r_target_base > rdc_pkg::BASE_HIGH) begin
                        n_base = rdc_pkg::BASE_HIGH;
                    end else begin
                        n_base = r_target_base;
                    end
                    n_quo   = i_number_value;
                    n_rem   = '0;
                    n_bit   = BW'(VALUE_BITS - 1);
                    n_top   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo = step_quo;
                n_rem = step_rem;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    // The digit is complete; keep it while the stack has room.
                    if (r_top < TW'(STACK_DEPTH)) begin
                        push_en = 1'b1;
                        n_top   = r_top + 1'b1;
                    end
                    n_rem = '0;
                    n_bit = BW'(VALUE_BITS - 1);
                    if (step_quo == '0) begin
                        n_state = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (r_top != '0) begin
                    pop_en     = 1'b1;
                    n_top      = top_dec;
                    n_rd_valid = 1'b1;
                    n_rd_last  = (top_dec == '0);
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_target_base <= rdc_pkg::BASE_RESET;
            r_bit         <= '0;
            r_top         <= '0;
            r_rd_valid    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_target_base <= n_target_base;
            r_bit         <= n_bit;
            r_top         <= n_top;
            r_rd_valid    <= n_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base    <= n_base;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_rd_last <= n_rd_last;
    end

    // Stack memory: one write port for pushes, one registered read for pops.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stack[r_top[AW-1:0]] <= step_rem;
        end
        if (pop_en) begin
            r_rd_data <= r_stack[rd_addr];
        end
    end

    assign o_result_strobe = r_rd_valid;
    assign o_digit_char    = rdc_pkg::digit_to_ascii(r_rd_data);
    assign o_last_digit    = r_rd_last;

    // The stack count never passes the stack depth.
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TW'(STACK_DEPTH))
        else $error("digit stack count beyond depth");

    // The partial remainder stays below the base through the division.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_base))
        else $error("partial remainder not below base");

    // No character leaves while digits are still being produced.
    a_no_strobe_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !o_result_strobe)
        else $error("character strobed during division");

    // The final character is strobed only once the stack is empty.
    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_last_digit) |-> (r_top == '0))
        else $error("last character flagged with digits left");

    // An accepted request always starts a division.
    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_DIV))
        else $error("accepted request did not start a division");

endmodule
